/* rtl/core/bapd_pkg.sv */
// ----------------------------------------------------------------------------
// bapd_pkg
// Shared types and constants of the box-average pyramid downsampler.
// ----------------------------------------------------------------------------
package bapd_pkg;

  // Default sizes of the pyramid.
  localparam int DEF_MAX_WIDTH  = 512;
  localparam int DEF_MAX_PASSES = 4;
  localparam int DEF_MIN_DIM    = 64;

  // Largest frame height taken from the height register.
  localparam int MAX_HEIGHT = 4096;

  // Register sizes and reset values.
  localparam int FRAME_WIDTH_W    = 10;
  localparam int FRAME_HEIGHT_W   = 13;
  localparam int CFG_DATA_W       = 13;
  localparam int CFG_IDX_W        = 2;
  localparam int RST_FRAME_WIDTH  = 512;
  localparam int RST_FRAME_HEIGHT = 512;

  // Colour channel width and the width of a horizontal pair sum.
  localparam int CHAN_W = 8;
  localparam int PSUM_W = CHAN_W + 1;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1
  } cfg_idx_e;

  // One RGB pixel.
  typedef struct packed {
    logic [CHAN_W-1:0] r;
    logic [CHAN_W-1:0] g;
    logic [CHAN_W-1:0] b;
  } pix_t;

  // Horizontal pair sum of two pixels, one line store word.
  typedef struct packed {
    logic [PSUM_W-1:0] r;
    logic [PSUM_W-1:0] g;
    logic [PSUM_W-1:0] b;
  } psum_t;

  // An item travelling between halving stages.
  typedef struct packed {
    logic valid;
    pix_t pix;
  } item_t;

  // Control handed from the top level to each stage.
  typedef struct packed {
    logic adv;     // the pipeline moves on this cycle
    logic clr;     // a register write restarts the frame
    logic active;  // this stage halves the image
  } stage_ctrl_t;

endpackage

/* rtl/core/bapd_in_if.sv */
// ----------------------------------------------------------------------------
// bapd_in_if
// Valid/ready channel carrying input pixels of the pyramid downsampler.
// ----------------------------------------------------------------------------
interface bapd_in_if;

  logic                           valid;
  logic                           ready;
  logic [bapd_pkg::CHAN_W-1:0]    red_in;
  logic [bapd_pkg::CHAN_W-1:0]    green_in;
  logic [bapd_pkg::CHAN_W-1:0]    blue_in;

  modport source (output valid, output red_in, output green_in, output blue_in,
                  input ready);
  modport sink (input valid, input red_in, input green_in, input blue_in,
                output ready);

endinterface

/* rtl/core/bapd_out_if.sv */
// ----------------------------------------------------------------------------
// bapd_out_if
// Valid/ready channel carrying reduced pixels of the pyramid downsampler.
// ----------------------------------------------------------------------------
interface bapd_out_if;

  logic                           valid;
  logic                           ready;
  logic [bapd_pkg::CHAN_W-1:0]    red_out;
  logic [bapd_pkg::CHAN_W-1:0]    green_out;
  logic [bapd_pkg::CHAN_W-1:0]    blue_out;
  logic                           frame_end;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  output frame_end, input ready);
  modport sink (input valid, input red_out, input green_out, input blue_out,
                input frame_end, output ready);

endinterface

/* rtl/core/box_average_pyramid_downsampler.sv */
// ----------------------------------------------------------------------------
// box_average_pyramid_downsampler
// Streaming 2x2 box-filter decimation pyramid over raster-order RGB pixels.
// ----------------------------------------------------------------------------
// The block takes one pixel per clock while input is not refused, and halves
// the frame once for every stage whose input is at least MIN_DIM pixels wide
// and high, up to MAX_PASSES stages; with no pass the pixels come out
// unchanged. Every item crosses all MAX_PASSES stages through their first and
// second slots, then the output register. Each stage keeps its pair sums in
// its own line store bank with a registered read, which sets the stage depth.
// Input is refused only while the last stage holds a result and the output
// register is still occupied and not being taken. A write to a known register
// restarts the frame with the next pixel and needs no clearing pass.
// Frame_end marks the last pixel of the reduced frame.
// ----------------------------------------------------------------------------
module box_average_pyramid_downsampler #(
  parameter int MAX_WIDTH  = bapd_pkg::DEF_MAX_WIDTH,
  parameter int MAX_PASSES = bapd_pkg::DEF_MAX_PASSES,
  parameter int MIN_DIM    = bapd_pkg::DEF_MIN_DIM
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bapd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bapd_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  bapd_in_if.sink                         pix_i,
  bapd_out_if.source                      pix_o
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int HW = $clog2(bapd_pkg::MAX_HEIGHT + 1);
  localparam int RW = $clog2(bapd_pkg::MAX_HEIGHT);
  localparam int RST_W = (MAX_WIDTH < bapd_pkg::RST_FRAME_WIDTH) ?
                         MAX_WIDTH : bapd_pkg::RST_FRAME_WIDTH;

  logic [WW-1:0]                  width_q;
  logic [HW-1:0]                  height_q;
  logic [WW-1:0]                  width_wr;
  logic [HW-1:0]                  height_wr;
  logic [bapd_pkg::FRAME_WIDTH_W-1:0]  wdata_w;
  logic [bapd_pkg::FRAME_HEIGHT_W-1:0] wdata_h;
  logic                           cfg_clr;

  logic [WW-1:0]                  stage_w [MAX_PASSES];
  logic [HW-1:0]                  stage_h [MAX_PASSES];
  logic [MAX_PASSES-1:0]          active;
  logic [WW-1:0]                  out_w;
  logic [HW-1:0]                  out_h;

  bapd_pkg::item_t                chain [MAX_PASSES+1];
  bapd_pkg::stage_ctrl_t          ctrl  [MAX_PASSES];
  bapd_pkg::item_t                last_item;
  logic                           adv;

  logic [CW-1:0]                  out_col_q;
  logic [RW-1:0]                  out_row_q;
  logic                           out_col_last;
  logic                           out_row_last;
  logic                           out_valid_q;
  bapd_pkg::pix_t                 out_pix_q;
  logic                           frame_end_q;

  // Dimension clamping of written register values.
  always_comb begin
    wdata_w = cfg_wdata_i[bapd_pkg::FRAME_WIDTH_W-1:0];
    wdata_h = cfg_wdata_i[bapd_pkg::FRAME_HEIGHT_W-1:0];
    if (wdata_w == '0) begin
      width_wr = WW'(1);
    end else if (32'(wdata_w) > 32'(MAX_WIDTH)) begin
      width_wr = WW'(MAX_WIDTH);
    end else begin
      width_wr = WW'(wdata_w);
    end
    if (wdata_h == '0) begin
      height_wr = HW'(1);
    end else if (32'(wdata_h) > 32'(bapd_pkg::MAX_HEIGHT)) begin
      height_wr = HW'(bapd_pkg::MAX_HEIGHT);
    end else begin
      height_wr = HW'(wdata_h);
    end
  end

  // Frame size registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WW'(RST_W);
      height_q <= HW'(bapd_pkg::RST_FRAME_HEIGHT);
    end else if (cfg_we_i) begin
      case (bapd_pkg::cfg_idx_e'(cfg_idx_i))
        bapd_pkg::CFG_FRAME_WIDTH:  width_q  <= width_wr;
        bapd_pkg::CFG_FRAME_HEIGHT: height_q <= height_wr;
        default: ;
      endcase
    end
  end

  // A write to a known register restarts the frame.
  always_comb begin
    case (bapd_pkg::cfg_idx_e'(cfg_idx_i))
      bapd_pkg::CFG_FRAME_WIDTH,
      bapd_pkg::CFG_FRAME_HEIGHT: cfg_clr = cfg_we_i;
      default:                    cfg_clr = 1'b0;
    endcase
  end

  // Per-stage sizes, the active stages and the reduced frame size. The stage
  // test is monotonic, so the active stages always form a prefix.
  always_comb begin
    out_w = width_q;
    out_h = height_q;
    for (int s = 0; s < MAX_PASSES; s++) begin
      stage_w[s] = WW'(width_q >> s);
      stage_h[s] = HW'(height_q >> s);
      active[s]  = (32'(stage_w[s]) >= 32'(MIN_DIM)) &&
                   (32'(stage_h[s]) >= 32'(MIN_DIM));
      if (active[s]) begin
        out_w = WW'(width_q >> (s + 1));
        out_h = HW'(height_q >> (s + 1));
      end
    end
  end

  // The pipeline moves unless a finished item would land on an untaken one.
  assign last_item = chain[MAX_PASSES];
  assign adv       = !last_item.valid || !out_valid_q || pix_o.ready;
  assign pix_i.ready = adv;

  assign chain[0].valid = pix_i.valid;
  assign chain[0].pix.r = pix_i.red_in;
  assign chain[0].pix.g = pix_i.green_in;
  assign chain[0].pix.b = pix_i.blue_in;

  // Cascade of halving stages.
  for (genvar s = 0; s < MAX_PASSES; s++) begin : g_stage
    assign ctrl[s].adv    = adv;
    assign ctrl[s].clr    = cfg_clr;
    assign ctrl[s].active = active[s];

    bapd_stage #(
      .MAX_WIDTH (MAX_WIDTH),
      .STAGE     (s)
    ) u_stage (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl[s]),
      .stage_w_i (stage_w[s]),
      .stage_h_i (stage_h[s]),
      .item_i    (chain[s]),
      .item_o    (chain[s+1])
    );
  end

  // Position within the reduced frame.
  assign out_col_last = (32'(out_col_q) + 32'd1) >= 32'(out_w);
  assign out_row_last = (32'(out_row_q) + 32'd1) >= 32'(out_h);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_col_q <= '0;
      out_row_q <= '0;
    end else if (cfg_clr) begin
      out_col_q <= '0;
      out_row_q <= '0;
    end else if (adv && last_item.valid) begin
      if (out_col_last) begin
        out_col_q <= '0;
        out_row_q <= out_row_last ? '0 : out_row_q + 1'b1;
      end else begin
        out_col_q <= out_col_q + 1'b1;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && last_item.valid) begin
      out_valid_q <= 1'b1;
    end else if (pix_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && last_item.valid) begin
      out_pix_q   <= last_item.pix;
      frame_end_q <= out_col_last && out_row_last;
    end
  end

  assign pix_o.valid     = out_valid_q;
  assign pix_o.red_out   = out_pix_q.r;
  assign pix_o.green_out = out_pix_q.g;
  assign pix_o.blue_out  = out_pix_q.b;
  assign pix_o.frame_end = frame_end_q;

  // The output position always lies inside the reduced frame.
  a_out_col_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(out_col_q) < 32'(out_w))
    else $error("output column outside the reduced frame");

  a_out_row_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(out_row_q) < 32'(out_h))
    else $error("output row outside the reduced frame");

  // Loading the last pixel of a frame wraps the position to the origin.
  a_frame_end_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && last_item.valid && out_col_last && out_row_last
    |=> out_col_q == '0 && out_row_q == '0)
    else $error("frame end did not wrap the output position");

  // A result that waits untaken is never overwritten.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !pix_o.ready && last_item.valid
    |=> out_valid_q && $stable(out_pix_q))
    else $error("waiting result overwritten");

endmodule

/* rtl/core/bapd_stage.sv */
// ----------------------------------------------------------------------------
// bapd_stage
// One 2x2 halving stage: pending left pixel, a line store bank of horizontal
// pair sums and a first and second slot from input item to averaged output.
// ----------------------------------------------------------------------------
module bapd_stage #(
  parameter int MAX_WIDTH = bapd_pkg::DEF_MAX_WIDTH,
  parameter int STAGE     = 0
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  bapd_pkg::stage_ctrl_t                 ctrl_i,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]        stage_w_i,
  input  logic [$clog2(bapd_pkg::MAX_HEIGHT+1)-1:0] stage_h_i,
  input  bapd_pkg::item_t                       item_i,
  output bapd_pkg::item_t                       item_o
);

  localparam int CW       = $clog2(MAX_WIDTH);
  localparam int RW       = $clog2(bapd_pkg::MAX_HEIGHT);
  localparam int BANK_RAW = MAX_WIDTH >> (STAGE + 1);
  localparam int DEPTH    = (BANK_RAW < 2) ? 2 : BANK_RAW;
  localparam int AW       = $clog2(DEPTH);
  localparam int AVG_W    = bapd_pkg::PSUM_W + 1;

  logic [CW-1:0]         col_q;
  logic [RW-1:0]         row_q;
  bapd_pkg::pix_t        pend_q;
  logic                  a_valid_q;
  logic                  a_bypass_q;
  bapd_pkg::pix_t        a_pix_q;
  bapd_pkg::psum_t       a_sum_q;
  bapd_pkg::psum_t       rd_data_q;
  logic                  out_valid_q;
  bapd_pkg::pix_t        out_pix_q;
  bapd_pkg::psum_t       bank_q [DEPTH];

  logic                  take;
  logic                  col_last;
  logic                  row_last;
  logic                  wr_en;
  logic                  rd_en;
  logic                  pend_en;
  logic [AW-1:0]         addr;
  bapd_pkg::psum_t       sum;
  logic [AVG_W-1:0]      avg_r;
  logic [AVG_W-1:0]      avg_g;
  logic [AVG_W-1:0]      avg_b;
  bapd_pkg::pix_t        avg_pix;

  // Position decode and the horizontal pair sum of the arriving pixel.
  always_comb begin
    take     = ctrl_i.adv && item_i.valid && ctrl_i.active;
    col_last = (32'(col_q) + 32'd1) >= 32'(stage_w_i);
    row_last = (32'(row_q) + 32'd1) >= 32'(stage_h_i);
    addr     = AW'(col_q >> 1);
    sum.r    = {1'b0, pend_q.r} + {1'b0, item_i.pix.r};
    sum.g    = {1'b0, pend_q.g} + {1'b0, item_i.pix.g};
    sum.b    = {1'b0, pend_q.b} + {1'b0, item_i.pix.b};
    // Even columns park the pixel; odd columns store or combine a pair sum.
    pend_en  = take && !col_q[0] && !col_last;
    wr_en    = take && col_q[0] && !row_q[0] && !row_last;
    rd_en    = take && col_q[0] && row_q[0];
  end

  // Column and row of the next item entering this stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (ctrl_i.clr) begin
      col_q <= '0;
      row_q <= '0;
    end else if (take) begin
      if (col_last) begin
        col_q <= '0;
        row_q <= row_last ? '0 : row_q + 1'b1;
      end else begin
        col_q <= col_q + 1'b1;
      end
    end
  end

  // Pending left pixel of the current pair.
  always_ff @(posedge clk_i) begin
    if (pend_en) begin
      pend_q <= item_i.pix;
    end
  end

  // Line store bank. A read on an odd row and the write of the same entry on
  // the next even row are a line apart, so the two never overlap.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      bank_q[addr] <= sum;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= bank_q[addr];
    end
  end

  // First slot: control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q  <= 1'b0;
      a_bypass_q <= 1'b0;
    end else if (ctrl_i.adv) begin
      a_valid_q  <= ctrl_i.active ? rd_en : item_i.valid;
      a_bypass_q <= !ctrl_i.active;
    end
  end

  // First slot: payload.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv) begin
      a_pix_q <= item_i.pix;
      a_sum_q <= sum;
    end
  end

  // Four-pixel sum divided by four.
  always_comb begin
    avg_r     = {1'b0, rd_data_q.r} + {1'b0, a_sum_q.r};
    avg_g     = {1'b0, rd_data_q.g} + {1'b0, a_sum_q.g};
    avg_b     = {1'b0, rd_data_q.b} + {1'b0, a_sum_q.b};
    avg_pix.r = avg_r[AVG_W-1:2];
    avg_pix.g = avg_g[AVG_W-1:2];
    avg_pix.b = avg_b[AVG_W-1:2];
  end

  // Second slot: the item leaving this stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.adv) begin
      out_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv) begin
      out_pix_q <= a_bypass_q ? a_pix_q : avg_pix;
    end
  end

  assign item_o = {out_valid_q, out_pix_q};

endmodule

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench of the box-average pyramid downsampler.
// ----------------------------------------------------------------------------
// A short table of directed items checks the reset frame size, zero and
// oversized register values, ignored register indexes and pass-through
// behaviour against values typed into the table. Random phases then drive
// pass-through frames of many sizes with frame wrap, and one and two halving
// levels with odd widths. Each reduced pixel of a random phase is compared
// with a pyramid model kept in the bench; channels idle at random unless calm.
// ----------------------------------------------------------------------------
module tb_top;
  import bapd_pkg::*;

  localparam int LVL_MAX       = DEF_MAX_PASSES;
  localparam int LINE_MAX      = DEF_MAX_WIDTH;
  localparam int SIDE_MIN      = DEF_MIN_DIM;
  localparam int SETTLE_CYCLES = 4 * (2 * DEF_MAX_PASSES + 1);
  localparam int IDLE_PCT      = 27;
  localparam int MAX_REPORTS   = 30;
  localparam int TIMEOUT_TICKS = 1000000;

  // Indexes past the end of the register list, which the block ignores.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_PAST_END = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOP      = 2'd3;

  typedef struct packed {
    pix_t px;
    logic frame_end;
  } reduced_t;

  typedef enum {ROW_REG, ROW_PIX} row_kind_e;
  typedef enum {GET_MODEL, GET_NONE, GET_TYPED} row_get_e;

  typedef struct {
    row_kind_e                 kind;
    logic [CFG_IDX_W-1:0]      idx;
    logic [CFG_DATA_W-1:0]     val;
    pix_t                      px;
    row_get_e                  get;
    logic                      frame_end;
  } plan_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  bit                    calm;

  int unsigned pixels_sent;
  int unsigned checked;
  int unsigned frame_ends;
  int unsigned reg_writes;
  int unsigned fails;
  int unsigned by_depth [LVL_MAX+1];

  plan_row_t plan [$];
  reduced_t  reduced_q [$];

  // Model of the pyramid: registers, per-level geometry and line stores.
  logic [FRAME_WIDTH_W-1:0]  width_reg;
  logic [FRAME_HEIGHT_W-1:0] height_reg;
  int unsigned passes;
  int unsigned lvl_w [LVL_MAX];
  int unsigned lvl_h [LVL_MAX];
  int unsigned lvl_col [LVL_MAX];
  int unsigned lvl_row [LVL_MAX];
  pix_t        left_pix [LVL_MAX];
  psum_t       pair_line [LVL_MAX][LINE_MAX/2];
  int unsigned dst_w, dst_h, dst_col, dst_row;

  bapd_in_if  pix_in ();
  bapd_out_if pix_out ();

  box_average_pyramid_downsampler uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pix_i       (pix_in),
    .pix_o       (pix_out)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(TIMEOUT_TICKS);
    $display("status: fail");
    $finish;
  end

  // Recompute the level geometry from the registers and restart the frame.
  function automatic void restart_pyramid();
    int unsigned w, h;
    w = width_reg;
    h = height_reg;
    if (w < 1) w = 1;
    if (w > LINE_MAX) w = LINE_MAX;
    if (h < 1) h = 1;
    if (h > MAX_HEIGHT) h = MAX_HEIGHT;
    passes = 0;
    while (passes < LVL_MAX && w >= SIDE_MIN && h >= SIDE_MIN) begin
      lvl_w[passes] = w;
      lvl_h[passes] = h;
      w = w / 2;
      h = h / 2;
      passes++;
    end
    dst_w = w;
    dst_h = h;
    for (int i = 0; i < LVL_MAX; i++) begin
      lvl_col[i] = 0;
      lvl_row[i] = 0;
    end
    dst_col = 0;
    dst_row = 0;
  endfunction

  // Push one input pixel through every halving level; returns 1 when the
  // last level completes a reduced pixel.
  function automatic bit reduce_pixel(input pix_t px, output pix_t q, output logic last);
    pix_t        p;
    psum_t       sum;
    int unsigned c, r, k, acc;
    p    = px;
    q    = px;
    last = 1'b0;
    for (int unsigned s = 0; s < passes; s++) begin
      c = lvl_col[s];
      r = lvl_row[s];
      if (c + 1 >= lvl_w[s]) begin
        lvl_col[s] = 0;
        lvl_row[s] = (r + 1 >= lvl_h[s]) ? 0 : r + 1;
      end else begin
        lvl_col[s] = c + 1;
      end
      // An even column waits for its right-hand neighbour; an odd last one is dropped.
      if (c % 2 == 0) begin
        if (c + 1 < lvl_w[s]) left_pix[s] = p;
        return 1'b0;
      end
      sum.r = left_pix[s].r + p.r;
      sum.g = left_pix[s].g + p.g;
      sum.b = left_pix[s].b + p.b;
      k = c / 2;
      // An even row only leaves its pair sums for the row below.
      if (r % 2 == 0) begin
        if (r + 1 < lvl_h[s]) pair_line[s][k] = sum;
        return 1'b0;
      end
      acc = pair_line[s][k].r + sum.r;
      p.r = CHAN_W'(acc >> 2);
      acc = pair_line[s][k].g + sum.g;
      p.g = CHAN_W'(acc >> 2);
      acc = pair_line[s][k].b + sum.b;
      p.b = CHAN_W'(acc >> 2);
    end
    last = (dst_col + 1 >= dst_w) && (dst_row + 1 >= dst_h);
    if (dst_col + 1 >= dst_w) begin
      dst_col = 0;
      dst_row = (dst_row + 1 >= dst_h) ? 0 : dst_row + 1;
    end else begin
      dst_col++;
    end
    q = p;
    return 1'b1;
  endfunction

  function automatic void plan_reg(input logic [CFG_IDX_W-1:0] idx,
                                   input logic [CFG_DATA_W-1:0] val);
    plan_row_t row;
    row.kind      = ROW_REG;
    row.idx       = idx;
    row.val       = val;
    row.px        = '0;
    row.get       = GET_NONE;
    row.frame_end = 1'b0;
    plan.insert(plan.size(), row);
  endfunction

  function automatic void plan_pix(input pix_t px, input row_get_e get, input logic fe);
    plan_row_t row;
    row.kind      = ROW_PIX;
    row.idx       = '0;
    row.val       = '0;
    row.px        = px;
    row.get       = get;
    row.frame_end = fe;
    plan.insert(plan.size(), row);
  endfunction

  // Write one register while the block is idle and mirror it in the model.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    reg_writes++;
    if (idx == CFG_FRAME_WIDTH) begin
      width_reg = val[FRAME_WIDTH_W-1:0];
      restart_pyramid();
    end else if (idx == CFG_FRAME_HEIGHT) begin
      height_reg = val;
      restart_pyramid();
    end
  endtask

  // Hold the input back until every expected pixel is out and the pipe is empty.
  task automatic settle_out();
    @(negedge clk_i);
    pix_in.valid <= 1'b0;
    while (reduced_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Offer one pixel, wait for it to be taken and record what it should produce.
  task automatic send_pixel(input pix_t px, input row_get_e get, input logic fe);
    pix_t     q;
    logic     last;
    bit       got;
    reduced_t exp_px;
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      @(negedge clk_i);
      pix_in.valid <= 1'b0;
      @(posedge clk_i);
    end
    @(negedge clk_i);
    pix_in.valid    <= 1'b1;
    pix_in.red_in   <= px.r;
    pix_in.green_in <= px.g;
    pix_in.blue_in  <= px.b;
    do @(posedge clk_i); while (pix_in.ready !== 1'b1);
    pixels_sent++;
    got = reduce_pixel(px, q, last);
    if (get == GET_TYPED) begin
      exp_px.px        = px;
      exp_px.frame_end = fe;
      reduced_q.insert(reduced_q.size(), exp_px);
      by_depth[passes]++;
    end else if (get == GET_MODEL && got) begin
      exp_px.px        = q;
      exp_px.frame_end = last;
      reduced_q.insert(reduced_q.size(), exp_px);
      by_depth[passes]++;
    end
  endtask

  // New frame size, then a run of random pixels.
  task automatic random_phase(input int unsigned wv, input int unsigned hv,
                              input int unsigned n_pix, input bit pause_mid);
    logic [CFG_DATA_W-1:0] wdata;
    wdata                      = CFG_DATA_W'($urandom);
    wdata[FRAME_WIDTH_W-1:0]   = FRAME_WIDTH_W'(wv);
    settle_out();
    if ($urandom_range(0, 1) == 1) begin
      write_reg(CFG_FRAME_WIDTH, wdata);
      write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(hv));
    end else begin
      write_reg(CFG_FRAME_HEIGHT, CFG_DATA_W'(hv));
      write_reg(CFG_FRAME_WIDTH, wdata);
    end
    if ($urandom_range(0, 3) == 0) begin
      write_reg($urandom_range(0, 1) ? CFG_IDX_PAST_END : CFG_IDX_TOP,
                CFG_DATA_W'($urandom));
    end
    for (int unsigned k = 0; k < n_pix; k++) begin
      if (pause_mid && k == n_pix / 2) settle_out();
      send_pixel(24'($urandom), GET_MODEL, 1'b0);
    end
  endtask

  // Compare one field of a reduced pixel.
  task automatic check_field(input string name, input logic [CHAN_W-1:0] want,
                             input logic [CHAN_W-1:0] seen);
    if (seen !== want) begin
      fails++;
      if (fails <= MAX_REPORTS) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
      end
    end
  endtask

  // The receiver stalls at random except during the calm stretch.
  always @(negedge clk_i) begin
    pix_out.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Check each reduced pixel against the oldest expectation.
  always @(posedge clk_i) begin : check_out
    reduced_t want;
    if (rst_ni && pix_out.valid === 1'b1 && pix_out.ready === 1'b1) begin
      if (reduced_q.size() == 0) begin
        fails++;
        if (fails <= MAX_REPORTS) begin
          $display("%0t: unexpected pixel, expected none, actual %h %h %h end %b", $time,
                   pix_out.red_out, pix_out.green_out, pix_out.blue_out, pix_out.frame_end);
        end
      end else begin
        want = reduced_q.pop_front();
        checked++;
        if (want.frame_end) frame_ends++;
        check_field("red", want.px.r, pix_out.red_out);
        check_field("green", want.px.g, pix_out.green_out);
        check_field("blue", want.px.b, pix_out.blue_out);
        check_field("frame_end", CHAN_W'(want.frame_end), CHAN_W'(pix_out.frame_end));
      end
    end
  end

  initial begin : stimulus
    pix_in.valid    = 1'b0;
    pix_in.red_in   = '0;
    pix_in.green_in = '0;
    pix_in.blue_in  = '0;
    pix_out.ready   = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CFG_FRAME_WIDTH;
    cfg_wdata_i     = '0;
    rst_ni          = 1'b0;
    calm            = 1'b0;
    width_reg       = RST_FRAME_WIDTH;
    height_reg      = RST_FRAME_HEIGHT;
    restart_pyramid();

    // Directed table. After reset the frame is 512 by 512, so the first pixels
    // give nothing. A zero size counts as one, which passes every pixel
    // through as a one-pixel frame. Writes past the register list are ignored
    // and leave the frame position alone.
    plan_pix(24'h000000, GET_NONE, 1'b0);
    plan_pix(24'hFFFFFF, GET_NONE, 1'b0);
    plan_pix(24'hA55AC3, GET_NONE, 1'b0);
    plan_reg(CFG_FRAME_WIDTH, 13'd0);
    plan_reg(CFG_FRAME_HEIGHT, 13'd0);
    plan_pix(24'h000000, GET_TYPED, 1'b1);
    plan_pix(24'hFFFFFF, GET_TYPED, 1'b1);
    plan_pix(24'h0FF05A, GET_TYPED, 1'b1);
    plan_reg(CFG_FRAME_WIDTH, 13'h1C03);
    plan_reg(CFG_FRAME_HEIGHT, 13'd2);
    plan_pix(24'h800180, GET_TYPED, 1'b0);
    plan_pix(24'h7F7F7F, GET_TYPED, 1'b0);
    plan_pix(24'h123456, GET_TYPED, 1'b0);
    plan_reg(CFG_IDX_PAST_END, 13'h1FFF);
    plan_pix(24'hFEDCBA, GET_TYPED, 1'b0);
    plan_pix(24'h010101, GET_TYPED, 1'b0);
    plan_pix(24'hFF00FF, GET_TYPED, 1'b1);
    plan_reg(CFG_IDX_TOP, 13'h0AAA);
    plan_pix(24'h00FF00, GET_TYPED, 1'b0);
    plan_reg(CFG_FRAME_WIDTH, 13'h3FF);
    plan_reg(CFG_FRAME_HEIGHT, 13'h1FFF);
    plan_pix(24'h55AA55, GET_NONE, 1'b0);
    plan_pix(24'hAA55AA, GET_NONE, 1'b0);

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) begin
        settle_out();
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        send_pixel(plan[i].px, plan[i].get, plan[i].frame_end);
      end
    end

    // Pass-through frames: small sizes that wrap, then one side below the
    // halving limit.
    repeat (6) begin
      random_phase($urandom_range(0, 10), $urandom_range(0, 4), $urandom_range(15, 30), 1'b0);
    end
    repeat (2) begin
      random_phase($urandom_range(0, 1023), $urandom_range(0, SIDE_MIN - 1),
                   $urandom_range(20, 40), 1'b0);
    end
    repeat (2) begin
      random_phase($urandom_range(0, SIDE_MIN - 1), $urandom_range(0, 8191),
                   $urandom_range(20, 40), 1'b0);
    end

    // One halving level over the first two lines and into the third; the first run
    // pauses for the output to drain, the second has no idling on either side.
    for (int n = 0; n < 2; n++) begin : one_level
      int unsigned w;
      w    = $urandom_range(64, 72);
      calm = (n == 1);
      random_phase(w, $urandom_range(64, 200), 2 * w + $urandom_range(0, w / 2), n == 0);
      calm = 1'b0;
    end

    // Two halving levels, long enough for a reduced row of the second level.
    begin : two_levels
      int unsigned w;
      w = $urandom_range(128, 140);
      random_phase(w, $urandom_range(128, 300), 4 * w + $urandom_range(0, w / 4), 1'b0);
    end

    settle_out();
    $display("run covered %0d pixels in, %0d reduced pixels checked, %0d frame ends, %0d writes",
             pixels_sent, checked, frame_ends, reg_writes);
    $display("results at 0/1/2/3/4 halving levels: %0d %0d %0d %0d %0d, mismatches %0d",
             by_depth[0], by_depth[1], by_depth[2], by_depth[3], by_depth[4], fails);
    if (fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/bapd_pkg.sv
rtl/core/bapd_in_if.sv
rtl/core/bapd_out_if.sv
rtl/core/bapd_stage.sv
rtl/core/box_average_pyramid_downsampler.sv
dv/tb_top.sv
